// File: design/pfpp_pkg.sv
// ----------------------------------------------------------------------------
// Page framebuffer pixel plotter package
// Shared types and constants for the page-organized frame store.
// ----------------------------------------------------------------------------
`default_nettype none

package pfpp_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned DATA_W      = 8;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    COLOR_BLACK   = 2'd0,
    COLOR_WHITE   = 2'd1,
    COLOR_INVERSE = 2'd2,
    COLOR_NONE    = 2'd3
  } color_t;

  localparam logic [DATA_W-1:0] FILL_WHITE = 8'hFF;
  localparam logic [DATA_W-1:0] FILL_BLACK = 8'h00;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

// File: design/pfpp_store.sv
// ----------------------------------------------------------------------------
// Page framebuffer store
// Single-port-write, single-port-read frame memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpp_store (
  input  wire logic                          clk,
  input  wire pfpp_pkg::wr_req_t             wr,
  input  wire pfpp_pkg::rd_req_t             rd,
  output logic [pfpp_pkg::DATA_W-1:0]        rdata
);
  import pfpp_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/page_framebuffer_pixel_plotter_unit.sv
// A read item passes the s1 stage and then the output register before its byte shows on out_valid; out_stall holds it.
// Draw and read items are accepted one per cycle while in_stall is low; a draw reads the store, then writes back,
// with the written byte forwarded to an immediately following item on the same address.
// A clear item in black or white fills the store on its single write port; input stalls meanwhile.
// After reset a pass writes zeros to the whole store; no item is taken meanwhile.
// ----------------------------------------------------------------------------
// Page framebuffer pixel plotter
// Monochrome frame store organized in pages of eight vertical pixels per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_pixel_plotter_unit #(
  parameter int unsigned PANEL_WIDTH  = 128,
  parameter int unsigned PANEL_HEIGHT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic [1:0]         in_color,
  input  wire logic [9:0]         in_byte_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte_value
);
  import pfpp_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  logic              in_accept;
  logic              x_ok;
  logic              y_ok;
  logic [ADDR_W:0]   draw_addr;
  logic              draw_hit;
  logic [ADDR_W-1:0] rd_addr;

  logic              s1_valid_r, s1_valid_nxt;
  kind_t             s1_kind_r;
  color_t            s1_color_r;
  logic              s1_hit_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_mask_r;
  logic              s1_go;

  logic              fwd_r;
  logic [DATA_W-1:0] fwd_data_r;

  logic              sweep_r, sweep_nxt;
  logic [ADDR_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [DATA_W-1:0] fill_r, fill_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;

  logic [DATA_W-1:0] mem_q;
  logic [DATA_W-1:0] cur_byte;
  logic [DATA_W-1:0] new_byte;
  wr_req_t           wr;
  rd_req_t           rd;

  assign x_ok = !in_pos_x[15] && ($unsigned(in_pos_x) < 16'(PANEL_WIDTH));
  assign y_ok = !in_pos_y[15] && ($unsigned(in_pos_y) < 16'(PANEL_HEIGHT));
  assign draw_addr = (ADDR_W+1)'(in_pos_x[7:0])
                   + (ADDR_W+1)'(in_pos_y[5:3]) * (ADDR_W+1)'(PANEL_WIDTH);
  assign draw_hit = x_ok && y_ok && !draw_addr[ADDR_W];
  assign rd_addr = (kind_t'(in_kind) == KIND_READ) ? in_byte_index : draw_addr[ADDR_W-1:0];

  assign s1_go = !(s1_valid_r && s1_kind_r == KIND_READ && out_valid_r && out_stall);
  assign in_stall = sweep_r || (s1_valid_r && s1_kind_r == KIND_CLEAR) || !s1_go;
  assign in_accept = in_valid && !in_stall;

  assign cur_byte = fwd_r ? fwd_data_r : mem_q;

  always_comb begin
    case (s1_color_r)
      COLOR_BLACK:   new_byte = cur_byte & ~s1_mask_r;
      COLOR_WHITE:   new_byte = cur_byte | s1_mask_r;
      COLOR_INVERSE: new_byte = cur_byte ^ s1_mask_r;
      default:       new_byte = cur_byte;
    endcase
  end

  always_comb begin
    if (sweep_r) begin
      wr.en   = 1'b1;
      wr.addr = sweep_cnt_r;
      wr.data = fill_r;
    end else begin
      wr.en   = s1_valid_r && s1_kind_r == KIND_DRAW && s1_hit_r;
      wr.addr = s1_addr_r;
      wr.data = new_byte;
    end
    rd.en   = in_accept;
    rd.addr = rd_addr;
  end

  always_comb begin
    sweep_nxt     = sweep_r;
    sweep_cnt_nxt = sweep_cnt_r;
    fill_nxt      = fill_r;
    if (sweep_r) begin
      sweep_cnt_nxt = sweep_cnt_r + 1'b1;
      if (sweep_cnt_r == LAST_ADDR) begin
        sweep_nxt = 1'b0;
      end
    end else if (s1_valid_r && s1_kind_r == KIND_CLEAR &&
                 (s1_color_r == COLOR_BLACK || s1_color_r == COLOR_WHITE)) begin
      sweep_nxt     = 1'b1;
      sweep_cnt_nxt = '0;
      fill_nxt      = (s1_color_r == COLOR_WHITE) ? FILL_WHITE : FILL_BLACK;
    end

    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_valid_r && s1_kind_r == KIND_READ && s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      fill_r      <= FILL_BLACK;
      fwd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_r     <= sweep_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      fill_r      <= fill_nxt;
      if (in_accept) begin
        fwd_r <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r  <= kind_t'(in_kind);
      s1_color_r <= color_t'(in_color);
      s1_hit_r   <= draw_hit;
      s1_addr_r  <= rd_addr;
      s1_mask_r  <= DATA_W'(1) << in_pos_y[2:0];
      fwd_data_r <= wr.data;
    end
    if (s1_valid_r && s1_kind_r == KIND_READ && s1_go) begin
      out_data_r <= cur_byte;
    end
  end

  pfpp_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (mem_q)
  );

  assign out_valid      = out_valid_r;
  assign out_byte_value = out_data_r;

endmodule

`default_nettype wire
